// ----- design/tdnn_layer_forward_unit_macros.svh -----
// Assertion helpers for the forward unit
`ifndef TDNN_LAYER_FORWARD_UNIT_MACROS_SVH
`define TDNN_LAYER_FORWARD_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define TDNN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define TDNN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/tdnn_pkg.sv -----
// ----------------------------------------------------------------------------
// tdnn_pkg
// Shared codes, sizes and widths for the time-delay layer forward unit.
// ----------------------------------------------------------------------------
package tdnn_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Store sizes
  localparam int unsigned IN_MAX     = 64;
  localparam int unsigned OUT_MAX    = 64;
  localparam int unsigned TAPS_MAX   = 4;
  localparam int unsigned HIST_DEPTH = 8;

  // Request codes
  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_BIAS    = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IN_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUT_COUNT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_NUM_TAPS  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_0   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_1   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_2   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_3   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_USE_BIAS  = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  out_index;
    logic [1:0]  tap_index;
    logic [5:0]  elem_index;
    logic signed [15:0] sample_value;
  } req_t;

  typedef struct packed {
    logic [5:0]  result_index;
    logic signed [31:0] result_value;
    logic        frame_last;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;
endpackage

// ----- design/tdnn_if.sv -----
// ----------------------------------------------------------------------------
// tdnn_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface tdnn_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/tdnn_layer_forward_unit.sv -----
// ----------------------------------------------------------------------------
// tdnn_layer_forward_unit
// Streamed forward pass of a time-delay layer with one shared MAC unit.
// ----------------------------------------------------------------------------
// channel  dir  payload                                        handshake
// req      in   req_type out_index tap_index elem_index value  valid/ready
// rsp      out  result_index result_value frame_last           valid/ready
// cfg      in   register index, write data                     valid/ready
//
// Loads and non-final features leave the block idle. A frame-completing
// feature with enough history keeps it busy, per row: a bias read, one MAC
// issue per tap element, a drain step and an output step.
// Each result waits in the output register; a stalled sink holds the
// sequencer in its output step. Reset clears control, configuration and
// accumulator state; memories hold no reset value.
`include "tdnn_layer_forward_unit_macros.svh"
module tdnn_layer_forward_unit
  import tdnn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tdnn_if.sink   req_i,
  tdnn_if.sink   cfg_i,
  tdnn_if.source rsp_o
);
  localparam int unsigned EW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int unsigned OW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int unsigned TW = (TAPS_MAX > 1) ? $clog2(TAPS_MAX) : 1;
  localparam int unsigned HW = $clog2(HIST_DEPTH);
  localparam int unsigned FW = $clog2(HIST_DEPTH + 1);
  localparam int unsigned WDEPTH = OUT_MAX * TAPS_MAX * IN_MAX;
  localparam int unsigned HDEPTH = HIST_DEPTH * IN_MAX;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BIAS = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // Memories
  logic [15:0] wmem [WDEPTH];
  logic [15:0] bmem [OUT_MAX];
  logic [15:0] hmem [HDEPTH];
  logic [15:0] wrd_q, hrd_q, brd_q;

  // Configuration
  logic [6:0] idim_q, odim_q;
  logic [2:0] ntap_q;
  logic [2:0] dly_q [4];
  logic       bias_en_q;

  logic [2:0]    st_q;
  logic [HW-1:0] slot_q;
  logic [FW-1:0] seen_q;
  logic [OW-1:0] o_q;
  logic [TW-1:0] t_q;
  logic [EW-1:0] e_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] prod_q;
  logic          rd_v_q;
  logic          prod_v_q;
  rsp_t          rsp_q;
  logic          rsp_v_q;
  logic          rsp_load;

  // Clamped configuration
  logic [EW:0] idim;
  logic [OW:0] odim;
  logic [TW:0] ntap;
  logic [HW-1:0] dly [TAPS_MAX];
  logic [HW-1:0] maxd;

  always_comb begin
    if (idim_q == '0) idim = (EW+1)'(1);
    else if (32'(idim_q) > IN_MAX) idim = (EW+1)'(IN_MAX);
    else idim = (EW+1)'(idim_q);
    if (odim_q == '0) odim = (OW+1)'(1);
    else if (32'(odim_q) > OUT_MAX) odim = (OW+1)'(OUT_MAX);
    else odim = (OW+1)'(odim_q);
    if (ntap_q == '0) ntap = (TW+1)'(1);
    else if (32'(ntap_q) > TAPS_MAX) ntap = (TW+1)'(TAPS_MAX);
    else ntap = (TW+1)'(ntap_q);
    maxd = '0;
    for (int t = 0; t < TAPS_MAX; t++) begin
      if (t < 4) begin
        if (32'(dly_q[t]) >= HIST_DEPTH) dly[t] = HW'(HIST_DEPTH - 1);
        else dly[t] = HW'(dly_q[t]);
      end else begin
        dly[t] = '0;
      end
      if (t < 32'(ntap) && dly[t] > maxd) maxd = dly[t];
    end
  end

  // Input decode
  req_t r;
  logic req_acc, is_feat, is_end, compute;
  assign r = req_i.data;
  assign req_i.ready = (st_q == ST_IDLE);
  assign req_acc = req_i.valid && req_i.ready;
  assign is_feat = req_acc && r.req_type == REQ_FEATURE && 32'(r.elem_index) < 32'(idim);
  assign is_end = is_feat && 32'(r.elem_index) == 32'(idim) - 1;
  logic [FW-1:0] seen_nx;
  assign seen_nx = (32'(seen_q) < HIST_DEPTH) ? seen_q + 1'b1 : seen_q;
  assign compute = is_end && 32'(seen_nx) > 32'(maxd);

  // Read addresses for the current MAC step
  logic [HW-1:0] rslot;
  logic [$clog2(WDEPTH)-1:0] waddr_rd;
  logic [$clog2(HDEPTH)-1:0] haddr_rd;
  logic last_e, last_t, last_o;
  assign rslot = slot_q - dly[t_q];
  assign waddr_rd = $clog2(WDEPTH)'((32'(o_q) * TAPS_MAX + 32'(t_q)) * IN_MAX + 32'(e_q));
  assign haddr_rd = $clog2(HDEPTH)'(32'(rslot) * IN_MAX + 32'(e_q));
  assign last_e = 32'(e_q) == 32'(idim) - 1;
  assign last_t = 32'(t_q) == 32'(ntap) - 1;
  assign last_o = 32'(o_q) == 32'(odim) - 1;

  // Memory ports: write on requests, read during the MAC walk
  always_ff @(posedge clk_i) begin
    if (req_acc && r.req_type == REQ_WEIGHT && 32'(r.out_index) < OUT_MAX &&
        32'(r.tap_index) < TAPS_MAX && 32'(r.elem_index) < IN_MAX) begin
      wmem[$clog2(WDEPTH)'((32'(r.out_index) * TAPS_MAX + 32'(r.tap_index)) * IN_MAX
           + 32'(r.elem_index))] <= r.sample_value;
    end
    if (req_acc && r.req_type == REQ_BIAS && 32'(r.out_index) < OUT_MAX) begin
      bmem[OW'(r.out_index)] <= r.sample_value;
    end
    if (is_feat) begin
      hmem[$clog2(HDEPTH)'(32'(slot_q) * IN_MAX + 32'(r.elem_index))] <= r.sample_value;
    end
    wrd_q <= wmem[waddr_rd];
    hrd_q <= hmem[haddr_rd];
    brd_q <= bmem[o_q];
  end

  // Configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idim_q <= 7'd64; odim_q <= 7'd64; ntap_q <= 3'd1;
      for (int i = 0; i < 4; i++) dly_q[i] <= '0;
      bias_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_IN_WIDTH:   idim_q <= cfg_i.data.data[6:0];
        CFG_OUT_COUNT:  odim_q <= cfg_i.data.data[6:0];
        CFG_NUM_TAPS:   ntap_q <= cfg_i.data.data[2:0];
        CFG_DELAY_0:    dly_q[0] <= cfg_i.data.data[2:0];
        CFG_DELAY_1:    dly_q[1] <= cfg_i.data.data[2:0];
        CFG_DELAY_2:    dly_q[2] <= cfg_i.data.data[2:0];
        CFG_DELAY_3:    dly_q[3] <= cfg_i.data.data[2:0];
        CFG_USE_BIAS:   bias_en_q <= cfg_i.data.data[0];
        default: ;
      endcase
    end
  end

  // Saturate the accumulator
  logic signed [31:0] sat;
  always_comb begin
    if (acc_q > 64'sd2147483647) sat = 32'sh7fffffff;
    else if (acc_q < -64'sd2147483648) sat = 32'sh80000000;
    else sat = acc_q[31:0];
  end

  // MAC pipeline: registered memory read after issue, then a registered product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; prod_v_q <= 1'b0; prod_q <= '0;
    end else begin
      rd_v_q <= (st_q == ST_MAC);
      prod_v_q <= rd_v_q;
      if (rd_v_q) prod_q <= signed'(wrd_q) * signed'(hrd_q);
    end
  end

  // Accumulator: start from the bias on the first MAC cycle, then add products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (st_q == ST_MAC && !rd_v_q) begin
      acc_q <= bias_en_q ? 64'(signed'(brd_q)) <<< 8 : '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + 64'(prod_q);
    end
  end

  // Sequencer: bias read, MAC walk, drain, result hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; slot_q <= '0; seen_q <= '0;
      o_q <= '0; t_q <= '0; e_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (is_end) begin
            seen_q <= seen_nx;
            if (!compute) slot_q <= slot_q + 1'b1;
            else begin
              st_q <= ST_BIAS; o_q <= '0; t_q <= '0; e_q <= '0;
            end
          end
        end
        ST_BIAS: begin
          // bias of row o_q is read this cycle
          st_q <= ST_MAC;
        end
        ST_MAC: begin
          // issue one weight/history read per cycle
          if (last_e) begin
            e_q <= '0;
            if (last_t) st_q <= ST_LAST;
            else t_q <= t_q + 1'b1;
          end else begin
            e_q <= e_q + 1'b1;
          end
        end
        ST_LAST: begin
          // drain: last product forms, then is added
          if (!rd_v_q) st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (rsp_load) begin
            t_q <= '0; e_q <= '0;
            if (last_o) begin
              st_q <= ST_IDLE; slot_q <= slot_q + 1'b1;
            end else begin
              o_q <= o_q + 1'b1; st_q <= ST_BIAS;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Output register: load a new result or drop the accepted one
  assign rsp_load = (st_q == ST_OUT) && (!rsp_v_q || rsp_o.ready);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
      rsp_q <= '0;
    end else if (rsp_load) begin
      rsp_v_q <= 1'b1;
      rsp_q.result_index <= 6'(o_q);
      rsp_q.result_value <= sat;
      rsp_q.frame_last <= last_o;
    end else if (rsp_o.ready) begin
      rsp_v_q <= 1'b0;
    end
  end

  assign rsp_o.valid = rsp_v_q;
  assign rsp_o.data = rsp_q;

  logic last_row_ok;
  assign last_row_ok = 32'(rsp_q.result_index) == 32'(odim) - 1;

  `TDNN_ASSERT_IMP(a_no_req_busy, st_q != ST_IDLE, !req_i.ready, "request taken while busy")
  `TDNN_ASSERT_NXT(a_compute_starts, compute, st_q == ST_BIAS, "compute did not start")
  `TDNN_ASSERT_IMP(a_last_row, rsp_v_q && rsp_q.frame_last, last_row_ok, "frame_last on wrong row")
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time-delay layer forward unit.
// A scoreboard class predicts every result from the accepted requests and the
// register settings, and checks the result stream field by field. Directed
// phases come first: too little history, saturation over a wide frame,
// clamped register values and repeated delays. Random phases follow.
// ----------------------------------------------------------------------------
module testbench;
  import tdnn_pkg::*;

  localparam int unsigned NumOut   = 64;
  localparam int unsigned NumTaps  = 4;
  localparam int unsigned NumElem  = 64;
  localparam int unsigned NumSlots = 8;

  // Track layer state and queue the results each request should produce
  class layer_scoreboard;
    logic [15:0] weights [NumOut][NumTaps][NumElem];
    logic [15:0] biases [NumOut];
    logic [15:0] history [NumSlots][NumElem];
    bit          hist_written [NumSlots][NumElem];
    bit [2:0]    newest;
    int unsigned frames_seen;
    bit [6:0]    in_dim_raw, out_dim_raw;
    bit [2:0]    taps_raw;
    bit [2:0]    delays [NumTaps];
    bit          bias_on;
    rsp_t        expected_results [$];
    int unsigned errors, results_checked, frames_computed;

    function new();
      in_dim_raw  = 7'd64;
      out_dim_raw = 7'd64;
      taps_raw    = 3'd1;
      foreach (delays[t]) delays[t] = '0;
      bias_on     = 1'b1;
      newest      = '0;
      frames_seen = 0;
    endfunction

    function int clamp_dim(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int in_dim();
      return clamp_dim(in_dim_raw, NumElem);
    endfunction

    function int out_dim();
      return clamp_dim(out_dim_raw, NumOut);
    endfunction

    function int tap_count();
      return clamp_dim(taps_raw, NumTaps);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_IN_WIDTH:   in_dim_raw = data[6:0];
        CFG_OUT_COUNT:  out_dim_raw = data[6:0];
        CFG_NUM_TAPS:   taps_raw = data[2:0];
        CFG_DELAY_0:    delays[0] = data[2:0];
        CFG_DELAY_1:    delays[1] = data[2:0];
        CFG_DELAY_2:    delays[2] = data[2:0];
        CFG_DELAY_3:    delays[3] = data[2:0];
        CFG_USE_BIAS:   bias_on = data[0];
        default: ;
      endcase
    endfunction

    // Update the stores and, on a completed frame with enough history, compute every output row
    function void note_request(req_t r);
      int    idim, odim, taps, maxd;
      bit [2:0] slot;
      longint acc;
      rsp_t  res;
      idim = in_dim();
      odim = out_dim();
      taps = tap_count();
      maxd = 0;
      case (r.req_type)
        REQ_WEIGHT: weights[r.out_index][r.tap_index][r.elem_index] = r.sample_value;
        REQ_BIAS:   biases[r.out_index] = r.sample_value;
        REQ_FEATURE: begin
          if (r.elem_index >= idim) return;
          history[newest][r.elem_index] = r.sample_value;
          hist_written[newest][r.elem_index] = 1'b1;
          if (r.elem_index != idim - 1) return;
          if (frames_seen < NumSlots) frames_seen++;
          for (int t = 0; t < taps; t++) if (delays[t] > maxd) maxd = delays[t];
          if (frames_seen > maxd) begin
            frames_computed++;
            for (int o = 0; o < odim; o++) begin
              acc = bias_on ? longint'($signed(biases[o])) * 256 : 0;
              for (int t = 0; t < taps; t++) begin
                slot = newest - delays[t];
                for (int e = 0; e < idim; e++)
                  acc += longint'($signed(weights[o][t][e])) *
                         longint'($signed(history[slot][e]));
              end
              if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
              if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
              res.result_index = o[5:0];
              res.result_value = acc[31:0];
              res.frame_last   = (o == odim - 1);
              expected_results = {expected_results, res};
            end
          end
          newest = newest + 3'd1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result row %0d value %0d last %0b", $time,
                 got.result_index, got.result_value, got.frame_last);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (got.result_index !== want.result_index) begin
        $display("%0t: result_index expected %0d actual %0d", $time,
                 want.result_index, got.result_index);
        errors++;
      end
      if (got.result_value !== want.result_value) begin
        $display("%0t: result_value (row %0d) expected %0d actual %0d", $time,
                 want.result_index, want.result_value, got.result_value);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last (row %0d) expected %0b actual %0b", $time,
                 want.result_index, want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tdnn_if #(.T(req_t)) req_if ();
  tdnn_if #(.T(cfg_t)) cfg_if ();
  tdnn_if #(.T(rsp_t)) rsp_if ();

  tdnn_layer_forward_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  layer_scoreboard sb = new();
  int unsigned req_burst, rsp_burst, rsp_hold;
  int unsigned requests_sent, settings_used, random_requests;
  bit          gap_pending;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, and stretches without any
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_req(req_t r);
    int unsigned gap;
    gap = pick_gap(req_burst);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.data  = r;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [1:0] kind, int oi, int ti, int ei, logic [15:0] v);
    req_t r;
    r.req_type     = kind;
    r.out_index    = oi[5:0];
    r.tap_index    = ti[1:0];
    r.elem_index   = ei[5:0];
    r.sample_value = v;
    send_req(r);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned field);
    cfg_t c;
    // Random upper bits exercise the register masks
    c.index = idx;
    c.data  = ($urandom & 32'hFFFF_FF00) | field;
    cfg_if.data  = c;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(c.index, c.data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Hold off until every queued result is out, then let the block settle
  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Noise: unknown requests, out-of-range features and stray loads
  task automatic send_noise();
    int idim;
    idim = sb.in_dim();
    case ($urandom_range(0, 2))
      0: send_fields(2'd3, $urandom_range(0, 63), $urandom_range(0, 3),
                     $urandom_range(0, 63), 16'($urandom));
      1: if (idim < NumElem)
           send_fields(REQ_FEATURE, $urandom_range(0, 63), $urandom_range(0, 3),
                       $urandom_range(idim, 63), 16'($urandom));
      default: begin
        if ($urandom_range(0, 1) == 1)
          send_fields(REQ_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 3),
                      $urandom_range(0, 63), pick_sample());
        else
          send_fields(REQ_BIAS, $urandom_range(0, 63), $urandom_range(0, 3),
                      $urandom_range(0, 63), pick_sample());
      end
    endcase
  endtask

  // Deliver one frame in random order, the closing element last.
  // fill: 0 random values, 1 all most positive, 2 all most negative
  task automatic send_frame(int fill, bit noisy);
    int          idim, order [$], j, tmp;
    logic [15:0] v;
    idim = sb.in_dim();
    for (int e = 0; e < idim - 1; e++) order = {order, e};
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      if (noisy && $urandom_range(0, 9) == 0) send_noise();
      // Skip an element only where the slot already holds a written value
      if (fill == 0 && sb.hist_written[sb.newest][order[i]] &&
          $urandom_range(0, 7) == 0) continue;
      v = (fill == 1) ? 16'h7FFF : (fill == 2) ? 16'h8000 : pick_sample();
      send_fields(REQ_FEATURE, $urandom_range(0, 63), $urandom_range(0, 3), order[i], v);
    end
    v = (fill == 1) ? 16'h7FFF : (fill == 2) ? 16'h8000 : pick_sample();
    send_fields(REQ_FEATURE, $urandom_range(0, 63), $urandom_range(0, 3), idim - 1, v);
  endtask

  // Load every weight and bias that the current setting reads
  task automatic load_params(bit peak);
    for (int o = 0; o < sb.out_dim(); o++) begin
      send_fields(REQ_BIAS, o, $urandom_range(0, 3), $urandom_range(0, 63),
                  peak ? 16'h7FFF : pick_sample());
      for (int t = 0; t < sb.tap_count(); t++)
        for (int e = 0; e < sb.in_dim(); e++)
          send_fields(REQ_WEIGHT, o, t, e, peak ? 16'h7FFF : pick_sample());
    end
  endtask

  // One setting: optional history refill at a new width, then loads and frames
  task automatic run_phase(int idim, int odim, int taps, int d0, int d1, int d2, int d3,
                           bit bias_en, int frame_cnt, bit peak, bit refill);
    wait_idle();
    settings_used++;
    if (refill) begin
      // Fill all history slots at the new width, reading only the newest slot
      write_reg(CFG_IN_WIDTH, idim);
      write_reg(CFG_OUT_COUNT, 1);
      write_reg(CFG_NUM_TAPS, 1);
      write_reg(CFG_DELAY_0, 0);
      load_params(1'b0);
      repeat (NumSlots) send_frame(0, 1'b0);
      wait_idle();
    end
    write_reg(CFG_IN_WIDTH, idim);
    write_reg(CFG_OUT_COUNT, odim);
    write_reg(CFG_NUM_TAPS, taps);
    write_reg(CFG_DELAY_0, d0);
    write_reg(CFG_DELAY_1, d1);
    write_reg(CFG_DELAY_2, d2);
    write_reg(CFG_DELAY_3, d3);
    write_reg(CFG_USE_BIAS, bias_en);
    load_params(peak);
    for (int f = 0; f < frame_cnt; f++)
      send_frame(peak ? (f % 2) + 1 : 0, !peak);
  endtask

  // Result sink with random stalls
  initial begin
    rsp_if.ready = 1'b0;
    rsp_hold = 0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold > 0) begin
        rsp_if.ready = 1'b0;
        rsp_hold--;
      end else begin
        rsp_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) rsp_hold = pick_gap(rsp_burst);
      end
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  // Overall run limit
  initial begin
    #40_000_000;
    $display("tdnn_layer_forward_unit regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned guard;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Too little history: delay three, so the fourth frame is the first to yield
    settings_used++;
    write_reg(CFG_IN_WIDTH, 1);
    write_reg(CFG_OUT_COUNT, 1);
    write_reg(CFG_NUM_TAPS, 1);
    write_reg(CFG_DELAY_0, 3);
    write_reg(CFG_USE_BIAS, 1);
    send_fields(REQ_WEIGHT, 0, 0, 0, 16'h8000);
    send_fields(REQ_BIAS, 0, 3, 63, 16'h7FFF);
    send_fields(2'd3, 63, 3, 63, 16'hFFFF);
    send_fields(REQ_FEATURE, 63, 3, 63, 16'h1234);
    send_fields(REQ_WEIGHT, 63, 3, 63, 16'h8000);
    repeat (4) send_frame(0, 1'b0);

    // Wide frame with peak values: saturates high, then low
    run_phase(8, 2, 1, 0, 5, 6, 7, 1'b1, 2, 1'b1, 1'b1);
    // Every tap with distinct delays including the deepest, no bias
    run_phase(4, 3, 4, 0, 1, 2, 7, 1'b0, 4, 1'b0, 1'b0);
    // Clamped dimensions and tap count, all delays repeated at the deepest
    run_phase(0, 0, 7, 7, 7, 7, 7, 1'b1, 3, 1'b0, 1'b0);

    // Random settings with small sizes
    while (random_requests < 150) begin
      guard = requests_sent;
      run_phase($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 7),
                $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(2, 6),
                1'b0, 1'b0);
      random_requests += requests_sent - guard;
    end

    req_if.valid = 1'b0;
    guard = 0;
    while (sb.expected_results.size() != 0 && guard < 500_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);

    $display("Sent %0d requests over %0d register settings.", requests_sent, settings_used);
    $display("Checked %0d results from %0d computed frames, %0d errors, %0d missing.",
             sb.results_checked, sb.frames_computed, sb.errors,
             sb.expected_results.size());
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tdnn_layer_forward_unit regression: pass");
    end else begin
      $display("tdnn_layer_forward_unit regression: fail");
    end
    $finish;
  end
endmodule
